// ===== hdl/eig_pkg.sv =====
// Shared types, widths, codes and helper functions for the 2x2 eigen solver.
`timescale 1ns / 1ps

package eig_pkg;

	localparam int ELEM_W     = 16;
	localparam int TR_W       = ELEM_W + 1;
	localparam int PROD_W     = 2 * ELEM_W;
	localparam int TRSQ_W     = 2 * TR_W;
	localparam int DISC_W     = 36;
	localparam int DRT_W      = DISC_W / 2;
	localparam int VAL_W      = 18;
	localparam int COMP_W     = 19;
	localparam int MAG_W      = 19;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int LEN_W      = SQ_W + 1;
	localparam int UNIT_SHIFT = 28;
	localparam int DIVD_W     = 64;
	localparam int QUO_W      = UNIT_SHIFT + 1;
	localparam int NRT_IN_W   = QUO_W + 1;
	localparam int NRT_W      = NRT_IN_W / 2;
	localparam int VEC_W      = 16;

	typedef enum logic [1:0] {
		KIND_DISTINCT = 2'd0,
		KIND_REPEATED = 2'd1,
		KIND_COMPLEX  = 2'd2
	} root_kind_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] x;
		logic signed [COMP_W-1:0] y;
	} raw_vec_t;

	typedef struct packed {
		logic                     neg;
		logic signed [TR_W-1:0]   trace;
		logic signed [ELEM_W-1:0] a;
		logic signed [ELEM_W-1:0] b;
		logic signed [ELEM_W-1:0] c;
		logic signed [ELEM_W-1:0] d;
	} root_tag_t;

	typedef struct packed {
		root_kind_t              kind;
		logic signed [VAL_W-1:0] v1;
		logic signed [VAL_W-1:0] v2;
	} out_tag_t;

	function automatic logic signed [VAL_W-1:0] half_trunc(input logic signed [COMP_W-1:0] v);
		logic signed [COMP_W-1:0] t;
		t = v + $signed({{(COMP_W-1){1'b0}}, v[COMP_W-1]});
		return VAL_W'(t >>> 1);
	endfunction

	function automatic raw_vec_t raw_vec(
		input logic signed [ELEM_W-1:0] a,
		input logic signed [ELEM_W-1:0] b,
		input logic signed [ELEM_W-1:0] c,
		input logic signed [ELEM_W-1:0] d,
		input logic signed [VAL_W-1:0]  lam,
		input logic                     first
	);
		raw_vec_t r;
		priority if (b != '0) begin
			r.x = COMP_W'(b);
			r.y = COMP_W'(lam) - COMP_W'(a);
		end else if (c != '0) begin
			r.x = COMP_W'(lam) - COMP_W'(d);
			r.y = COMP_W'(c);
		end else begin
			r.x = first ? COMP_W'(1) : '0;
			r.y = first ? '0 : COMP_W'(1);
		end
		return r;
	endfunction

endpackage

// ===== hdl/eigen_solver_2x2_unit.sv =====
// Top level of the pipelined closed-form 2x2 eigen solver.
//
//  channel  | direction | handshake       | payload
//  ---------+-----------+-----------------+-----------------------------------------
//  matrix   | in        | start, busy     | top_left top_right bottom_left bottom_right
//  result   | out       | done (1 cycle)  | root_kind first_value second_value
//           |           |                 | first_vec_x/y second_vec_x/y
//
// One matrix per cycle; busy stays low. The path runs through the
// 18-stage discriminant square root, the 29-stage length divider and the
// 15-stage normalizing square root. Reset clears the valid bits of every
// stage; data registers are not reset. The pipeline never stalls.
`timescale 1ns / 1ps

module eigen_solver_2x2_unit
	import eig_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [ELEM_W-1:0] top_left,
	input  logic signed [ELEM_W-1:0] top_right,
	input  logic signed [ELEM_W-1:0] bottom_left,
	input  logic signed [ELEM_W-1:0] bottom_right,
	output logic                     done,
	output logic [1:0]               root_kind,
	output logic signed [VAL_W-1:0]  first_value,
	output logic signed [VAL_W-1:0]  second_value,
	output logic signed [VEC_W-1:0]  first_vec_x,
	output logic signed [VEC_W-1:0]  first_vec_y,
	output logic signed [VEC_W-1:0]  second_vec_x,
	output logic signed [VEC_W-1:0]  second_vec_y
);

	localparam int RTAG_W = $bits(root_tag_t);
	localparam int OTAG_W = $bits(out_tag_t);

	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [ELEM_W-1:0] a_s1, b_s1, c_s1, d_s1;
	logic signed [ELEM_W-1:0] a_s2, b_s2, c_s2, d_s2;
	logic signed [ELEM_W-1:0] a_s3, b_s3, c_s3, d_s3;
	logic signed [ELEM_W-1:0] a_s4, b_s4, c_s4, d_s4;
	logic signed [ELEM_W-1:0] a_s5, b_s5, c_s5, d_s5;
	logic signed [TR_W-1:0]   tr_c, tr_s2, tr_s3, tr_s4;
	logic signed [PROD_W-1:0] ad_s2, bc_s2;
	logic signed [TRSQ_W-1:0] trsq_s2;
	logic signed [DISC_W-1:0] det_c, disc_s3;
	logic                     neg_s4, neg_s5;
	logic [DISC_W-1:0]        mag_s4;

	root_tag_t                rtag_in, rtag_out;
	logic [RTAG_W-1:0]        rtag_out_v;
	logic                     rvld;
	logic [DRT_W-1:0]         root;
	logic signed [COMP_W-1:0] root_c, trc_c;
	logic signed [VAL_W-1:0]  v1_c, v2_c;

	logic signed [VAL_W-1:0]  v1_s5, v2_s5;
	root_kind_t               kind_c;
	root_kind_t               kind_s6;
	logic signed [VAL_W-1:0]  v1_s6, v2_s6;
	raw_vec_t                 vec1_s6, vec2_s6;

	out_tag_t                 otag_in, otag_out;
	logic [OTAG_W-1:0]        otag_out_v;
	logic                     nvld;
	logic signed [VEC_W-1:0]  comp [4];

	root_kind_t               kind_s7;
	logic signed [VAL_W-1:0]  v1_s7, v2_s7;
	logic signed [VEC_W-1:0]  x1_s7, y1_s7, x2_s7, y2_s7;

	assign busy = 1'b0;

	assign tr_c  = TR_W'(a_s1) + TR_W'(d_s1);
	assign det_c = DISC_W'(ad_s2) - DISC_W'(bc_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= rvld;
			vld_s6 <= vld_s5;
			vld_s7 <= nvld;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= top_left;
		b_s1    <= top_right;
		c_s1    <= bottom_left;
		d_s1    <= bottom_right;
		a_s2    <= a_s1;
		b_s2    <= b_s1;
		c_s2    <= c_s1;
		d_s2    <= d_s1;
		tr_s2   <= tr_c;
		ad_s2   <= PROD_W'(a_s1) * PROD_W'(d_s1);
		bc_s2   <= PROD_W'(b_s1) * PROD_W'(c_s1);
		trsq_s2 <= TRSQ_W'(tr_c) * TRSQ_W'(tr_c);
		a_s3    <= a_s2;
		b_s3    <= b_s2;
		c_s3    <= c_s2;
		d_s3    <= d_s2;
		tr_s3   <= tr_s2;
		disc_s3 <= DISC_W'(trsq_s2) - (det_c <<< 2);
		a_s4    <= a_s3;
		b_s4    <= b_s3;
		c_s4    <= c_s3;
		d_s4    <= d_s3;
		tr_s4   <= tr_s3;
		neg_s4  <= disc_s3[DISC_W-1];
		mag_s4  <= disc_s3[DISC_W-1] ? DISC_W'(-disc_s3) : DISC_W'(disc_s3);
	end

	assign rtag_in.neg   = neg_s4;
	assign rtag_in.trace = tr_s4;
	assign rtag_in.a     = a_s4;
	assign rtag_in.b     = b_s4;
	assign rtag_in.c     = c_s4;
	assign rtag_in.d     = d_s4;

	eig_isqrt_pipe #(
		.IN_W(DISC_W), .TAG_W(RTAG_W)
	) u_disc_rt (
		.clk(clk), .arst_n(arst_n), .vld_i(vld_s4), .rad_i(mag_s4),
		.tag_i(rtag_in), .vld_o(rvld), .root_o(root), .tag_o(rtag_out_v)
	);

	assign rtag_out = root_tag_t'(rtag_out_v);
	assign root_c   = $signed({1'b0, root});
	assign trc_c    = COMP_W'(rtag_out.trace);

	always_comb begin
		if (rtag_out.neg) begin
			v1_c = half_trunc(trc_c);
			v2_c = half_trunc(root_c);
		end else begin
			v1_c = half_trunc(trc_c + root_c);
			v2_c = half_trunc(trc_c - root_c);
		end
	end

	always_ff @(posedge clk) begin
		v1_s5  <= v1_c;
		v2_s5  <= v2_c;
		neg_s5 <= rtag_out.neg;
		a_s5   <= rtag_out.a;
		b_s5   <= rtag_out.b;
		c_s5   <= rtag_out.c;
		d_s5   <= rtag_out.d;
	end

	always_comb begin
		priority if (neg_s5) begin
			kind_c = KIND_COMPLEX;
		end else if (v1_s5 == v2_s5) begin
			kind_c = KIND_REPEATED;
		end else begin
			kind_c = KIND_DISTINCT;
		end
	end

	always_ff @(posedge clk) begin
		kind_s6 <= kind_c;
		v1_s6   <= v1_s5;
		v2_s6   <= v2_s5;
		vec1_s6 <= raw_vec(a_s5, b_s5, c_s5, d_s5, v1_s5, 1'b1);
		vec2_s6 <= raw_vec(a_s5, b_s5, c_s5, d_s5, v2_s5, 1'b0);
	end

	assign otag_in.kind = kind_s6;
	assign otag_in.v1   = v1_s6;
	assign otag_in.v2   = v2_s6;

	eig_vec_norm #(
		.TAG_W(OTAG_W)
	) u_norm (
		.clk(clk), .arst_n(arst_n), .vld_i(vld_s6), .first_i(vec1_s6),
		.second_i(vec2_s6), .tag_i(otag_in), .vld_o(nvld), .comp_o(comp),
		.tag_o(otag_out_v)
	);

	assign otag_out = out_tag_t'(otag_out_v);

	always_ff @(posedge clk) begin
		kind_s7 <= otag_out.kind;
		v1_s7   <= otag_out.v1;
		v2_s7   <= otag_out.v2;
		x1_s7   <= (otag_out.kind == KIND_COMPLEX) ? '0 : comp[0];
		y1_s7   <= (otag_out.kind == KIND_COMPLEX) ? '0 : comp[1];
		x2_s7   <= (otag_out.kind == KIND_DISTINCT) ? comp[2] : '0;
		y2_s7   <= (otag_out.kind == KIND_DISTINCT) ? comp[3] : '0;
	end

	assign done         = vld_s7;
	assign root_kind    = kind_s7;
	assign first_value  = v1_s7;
	assign second_value = v2_s7;
	assign first_vec_x  = x1_s7;
	assign first_vec_y  = y1_s7;
	assign second_vec_x = x2_s7;
	assign second_vec_y = y2_s7;

endmodule

// ===== hdl/eig_isqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage, with a tag carried alongside.
`timescale 1ns / 1ps

module eig_isqrt_pipe #(
	parameter int IN_W  = 36,
	parameter int TAG_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_i,
	input  logic [IN_W-1:0]       rad_i,
	input  logic [TAG_W-1:0]      tag_i,
	output logic                  vld_o,
	output logic [IN_W/2-1:0]     root_o,
	output logic [TAG_W-1:0]      tag_o
);

	localparam int OUT_W = IN_W / 2;

	logic             vld_s [OUT_W];
	logic [IN_W-1:0]  rem_s [OUT_W];
	logic [IN_W-1:0]  root_s [OUT_W];
	logic [TAG_W-1:0] tag_s [OUT_W];

	genvar k;
	for (k = 0; k < OUT_W; k++) begin : g_st
		logic             vld_in;
		logic [IN_W-1:0]  rem_in;
		logic [IN_W-1:0]  root_in;
		logic [TAG_W-1:0] tag_in;
		logic [IN_W-1:0]  bit_c;
		logic [IN_W:0]    trial;

		if (k == 0) begin : g_first
			assign vld_in  = vld_i;
			assign rem_in  = rad_i;
			assign root_in = '0;
			assign tag_in  = tag_i;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign tag_in  = tag_s[k-1];
		end

		assign bit_c = IN_W'(1) << (2 * (OUT_W - 1 - k));
		assign trial = {1'b0, root_in} + {1'b0, bit_c};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			tag_s[k] <= tag_in;
			if ({1'b0, rem_in} >= trial) begin
				rem_s[k]  <= rem_in - IN_W'(trial);
				root_s[k] <= (root_in >> 1) + bit_c;
			end else begin
				rem_s[k]  <= rem_in;
				root_s[k] <= root_in >> 1;
			end
		end
	end

	assign vld_o  = vld_s[OUT_W-1];
	assign root_o = root_s[OUT_W-1][OUT_W-1:0];
	assign tag_o  = tag_s[OUT_W-1];

endmodule

// ===== hdl/eig_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
`timescale 1ns / 1ps

module eig_div_pipe #(
	parameter int N_W   = 64,
	parameter int D_W   = 39,
	parameter int Q_W   = 29,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_i,
	input  logic [N_W-1:0]   num_i,
	input  logic [D_W-1:0]   den_i,
	input  logic [TAG_W-1:0] tag_i,
	output logic             vld_o,
	output logic [Q_W-1:0]   quo_o,
	output logic [TAG_W-1:0] tag_o
);

	localparam int X_W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

	logic             vld_s [Q_W];
	logic [X_W-1:0]   rem_s [Q_W];
	logic [D_W-1:0]   den_s [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W];
	logic [TAG_W-1:0] tag_s [Q_W];

	genvar k;
	for (k = 0; k < Q_W; k++) begin : g_st
		logic             vld_in;
		logic [X_W-1:0]   rem_in;
		logic [D_W-1:0]   den_in;
		logic [Q_W-1:0]   quo_in;
		logic [TAG_W-1:0] tag_in;
		logic [X_W-1:0]   trial;

		if (k == 0) begin : g_first
			assign vld_in = vld_i;
			assign rem_in = X_W'(num_i);
			assign den_in = den_i;
			assign quo_in = '0;
			assign tag_in = tag_i;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
			assign tag_in = tag_s[k-1];
		end

		assign trial = X_W'(den_in) << (Q_W - 1 - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			den_s[k] <= den_in;
			tag_s[k] <= tag_in;
			if (rem_in >= trial) begin
				rem_s[k] <= rem_in - trial;
				quo_s[k] <= quo_in | (Q_W'(1) << (Q_W - 1 - k));
			end else begin
				rem_s[k] <= rem_in;
				quo_s[k] <= quo_in;
			end
		end
	end

	assign vld_o = vld_s[Q_W-1];
	assign quo_o = quo_s[Q_W-1];
	assign tag_o = tag_s[Q_W-1];

endmodule

// ===== hdl/eig_vec_norm.sv =====
// Normalizes two eigenvectors to length two in Q2.13 through squaring, division and square root.
`timescale 1ns / 1ps

module eig_vec_norm
	import eig_pkg::*;
#(
	parameter int TAG_W = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    vld_i,
	input  raw_vec_t                first_i,
	input  raw_vec_t                second_i,
	input  logic [TAG_W-1:0]        tag_i,
	output logic                    vld_o,
	output logic signed [VEC_W-1:0] comp_o [4],
	output logic [TAG_W-1:0]        tag_o
);

	logic signed [COMP_W-1:0] comp_c [4];

	logic             vld_s1;
	logic             sgn_s1 [4];
	logic [MAG_W-1:0] mag_s1 [4];
	logic [TAG_W-1:0] tag_s1;

	logic             vld_s2;
	logic             sgn_s2 [4];
	logic [SQ_W-1:0]  sq_s2 [4];
	logic [TAG_W-1:0] tag_s2;

	logic              vld_s3;
	logic              sgn_s3 [4];
	logic [LEN_W-1:0]  len_s3 [2];
	logic [DIVD_W-1:0] divd_s3 [4];
	logic [TAG_W-1:0]  tag_s3;

	logic             dvld;
	logic [QUO_W-1:0] quo [4];
	logic [TAG_W:0]   dtag0;
	logic             dsgn [4];
	logic             rvld;
	logic [NRT_W-1:0] root [4];
	logic [TAG_W:0]   rtag0;
	logic             rsgn [4];

	assign comp_c[0] = first_i.x;
	assign comp_c[1] = first_i.y;
	assign comp_c[2] = second_i.x;
	assign comp_c[3] = second_i.y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= tag_i;
		tag_s2 <= tag_s1;
		tag_s3 <= tag_s2;
		for (int i = 0; i < 4; i++) begin
			sgn_s1[i]  <= comp_c[i][COMP_W-1];
			mag_s1[i]  <= comp_c[i][COMP_W-1] ? MAG_W'(-comp_c[i]) : MAG_W'(comp_c[i]);
			sgn_s2[i]  <= sgn_s1[i];
			sq_s2[i]   <= SQ_W'(mag_s1[i]) * SQ_W'(mag_s1[i]);
			sgn_s3[i]  <= sgn_s2[i];
			divd_s3[i] <= DIVD_W'({sq_s2[i], {UNIT_SHIFT{1'b0}}});
		end
		len_s3[0] <= LEN_W'(sq_s2[0]) + LEN_W'(sq_s2[1]);
		len_s3[1] <= LEN_W'(sq_s2[2]) + LEN_W'(sq_s2[3]);
	end

	eig_div_pipe #(
		.N_W(DIVD_W), .D_W(LEN_W), .Q_W(QUO_W), .TAG_W(TAG_W + 1)
	) u_div0 (
		.clk(clk), .arst_n(arst_n), .vld_i(vld_s3), .num_i(divd_s3[0]),
		.den_i(len_s3[0]), .tag_i({tag_s3, sgn_s3[0]}),
		.vld_o(dvld), .quo_o(quo[0]), .tag_o(dtag0)
	);

	assign dsgn[0] = dtag0[0];

	eig_isqrt_pipe #(
		.IN_W(NRT_IN_W), .TAG_W(TAG_W + 1)
	) u_rt0 (
		.clk(clk), .arst_n(arst_n), .vld_i(dvld), .rad_i(NRT_IN_W'(quo[0])),
		.tag_i(dtag0), .vld_o(rvld), .root_o(root[0]), .tag_o(rtag0)
	);

	assign rsgn[0] = rtag0[0];

	genvar k;
	for (k = 1; k < 4; k++) begin : g_comp
		eig_div_pipe #(
			.N_W(DIVD_W), .D_W(LEN_W), .Q_W(QUO_W), .TAG_W(1)
		) u_div (
			.clk(clk), .arst_n(arst_n), .vld_i(vld_s3), .num_i(divd_s3[k]),
			.den_i(len_s3[k/2]), .tag_i(sgn_s3[k]),
			.vld_o(), .quo_o(quo[k]), .tag_o(dsgn[k])
		);

		eig_isqrt_pipe #(
			.IN_W(NRT_IN_W), .TAG_W(1)
		) u_rt (
			.clk(clk), .arst_n(arst_n), .vld_i(dvld), .rad_i(NRT_IN_W'(quo[k])),
			.tag_i(dsgn[k]), .vld_o(), .root_o(root[k]), .tag_o(rsgn[k])
		);
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			comp_o[i] = rsgn[i] ? -VEC_W'(root[i]) : VEC_W'(root[i]);
		end
	end

	assign vld_o = rvld;
	assign tag_o = rtag0[TAG_W:1];

endmodule
